### design/spool_rotation_length_meter_unit_defines.svh
// assertion macros used by the checker file
`ifndef SPOOL_ROTATION_LENGTH_METER_UNIT_DEFINES_SVH
`define SPOOL_ROTATION_LENGTH_METER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRLM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srlm check failed");

// next-cycle implication, disabled during reset
`define SRLM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srlm check failed");

`endif

### design/srlm_pkg.sv
// types and constants of the spool rotation length meter
`default_nettype none

package srlm_pkg;

	typedef struct packed {
		logic [9:0] sample;
		logic       ms_tick;
	} item_t;

	typedef struct packed {
		logic [15:0] total_inches;
		logic [12:0] feet;
		logic [3:0]  inches_left;
		logic        over_limit;
		logic [15:0] event_count;
	} result_t;

	// configuration register indexes
	localparam logic [2:0] CFG_LOW_THRESHOLD  = 3'd0;
	localparam logic [2:0] CFG_HIGH_THRESHOLD = 3'd1;
	localparam logic [2:0] CFG_DEBOUNCE_MS    = 3'd2;
	localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd3;
	localparam logic [2:0] CFG_MIN_EVENTS     = 3'd4;
	localparam logic [2:0] CFG_INCHES_Q16     = 3'd5;
	localparam logic [2:0] CFG_MAX_INCHES     = 3'd6;

	// register reset values
	localparam logic [9:0]  RST_LOW_THRESHOLD  = 10'd30;
	localparam logic [9:0]  RST_HIGH_THRESHOLD = 10'd100;
	localparam logic [7:0]  RST_DEBOUNCE_MS    = 8'd2;
	localparam logic [15:0] RST_TIMEOUT_MS     = 16'd750;
	localparam logic [15:0] RST_MIN_EVENTS     = 16'd3;
	localparam logic [15:0] RST_INCHES_Q16     = 16'd11399;
	localparam logic [15:0] RST_MAX_INCHES     = 16'd143;

	localparam logic [15:0] CNT_MAX       = 16'hffff;
	localparam logic [32:0] ROUND_HALF    = 33'h0_0000_8000;
	localparam logic [12:0] FEET_MAX      = 13'h1fff;
	localparam logic [3:0]  INCHES_LEFT_MAX = 4'hf;

endpackage

`default_nettype wire

### design/spool_rotation_length_meter_unit.sv
// Spool rotation length meter: hysteresis event counter with run timeout and length report.
//
// item channel (item_valid/item_ready/item) carries one sensor sample and a millisecond
// tick flag per transfer. The band comparator, debounce, event count and idle timer are
// updated at the edge where the item transfers, so items may follow every cycle.
// result channel (result_valid/result_ready/result) carries one report per finished run
// whose event count exceeds min_events: rounded inches, feet, inches left, over-limit
// flag and the count. The length math for a report runs from the item that ends the run
// through count, rounded product and reciprocal quotient estimate registers, with the
// remainder correction in front of the result register. Throughput: one item per cycle.
// item_ready drops only when every length stage and the result register hold reports and
// the receiver stalls; items then wait at the source.
// Configuration: wr_en/wr_index/wr_data write a register at the clock edge; write only
// while the block is idle. Reset restores the default register values, clears both band
// flags, the run and all reports in flight.
`default_nettype none

module spool_rotation_length_meter_unit
	import srlm_pkg::*;
#(
	parameter int INCHES_PER_FOOT = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data
);

	localparam int unsigned RECIP = 65536 / INCHES_PER_FOOT;
	localparam logic [16:0] DIV   = 17'(INCHES_PER_FOOT);

	// configuration registers
	logic [9:0]  low_threshold_q;
	logic [9:0]  high_threshold_q;
	logic [7:0]  debounce_ms_q;
	logic [15:0] timeout_ms_q;
	logic [15:0] min_events_q;
	logic [15:0] inches_q16_q;
	logic [15:0] max_inches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q  <= RST_LOW_THRESHOLD;
			high_threshold_q <= RST_HIGH_THRESHOLD;
			debounce_ms_q    <= RST_DEBOUNCE_MS;
			timeout_ms_q     <= RST_TIMEOUT_MS;
			min_events_q     <= RST_MIN_EVENTS;
			inches_q16_q     <= RST_INCHES_Q16;
			max_inches_q     <= RST_MAX_INCHES;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LOW_THRESHOLD:  low_threshold_q  <= wr_data[9:0];
				CFG_HIGH_THRESHOLD: high_threshold_q <= wr_data[9:0];
				CFG_DEBOUNCE_MS:    debounce_ms_q    <= wr_data[7:0];
				CFG_TIMEOUT_MS:     timeout_ms_q     <= wr_data;
				CFG_MIN_EVENTS:     min_events_q     <= wr_data;
				CFG_INCHES_Q16:     inches_q16_q     <= wr_data;
				CFG_MAX_INCHES:     max_inches_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// run state
	logic        low_seen_q;
	logic        high_seen_q;
	logic [15:0] run_events_q;
	logic [15:0] ms_since_q;
	logic        run_active_q;

	// pipeline control
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic rdy_out, rdy3, rdy2, rdy1;

	assign rdy_out    = !out_valid_q || result_ready;
	assign rdy3       = !v3_s3 || rdy_out;
	assign rdy2       = !v2_s2 || rdy3;
	assign rdy1       = !v1_s1 || rdy2;
	assign item_ready = rdy1;

	logic item_xfer;
	assign item_xfer = item_valid && item_ready;

	// per-item update
	logic [15:0] ms_adv;
	logic        in_low, in_high, band_event, counted;
	logic [15:0] events_nxt, ms_nxt;
	logic        active_nxt, run_end, report;

	always_comb begin
		ms_adv = ms_since_q;
		if (run_active_q && item.ms_tick && ms_since_q != CNT_MAX) begin
			ms_adv = ms_since_q + 16'd1;
		end
		in_low     = item.sample < low_threshold_q;
		in_high    = !in_low && (item.sample > high_threshold_q);
		band_event = (in_low && !low_seen_q) || (in_high && !high_seen_q);
		// first event of a run is never debounced
		counted    = band_event && !(run_active_q && (ms_adv < 16'(debounce_ms_q)));
		events_nxt = run_events_q;
		ms_nxt     = ms_adv;
		active_nxt = run_active_q;
		if (counted) begin
			if (run_events_q != CNT_MAX) begin
				events_nxt = run_events_q + 16'd1;
			end
			ms_nxt     = '0;
			active_nxt = 1'b1;
		end
		run_end = active_nxt && (ms_nxt >= timeout_ms_q);
		report  = run_end && (events_nxt > min_events_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_seen_q   <= 1'b0;
			high_seen_q  <= 1'b0;
			run_events_q <= '0;
			ms_since_q   <= '0;
			run_active_q <= 1'b0;
		end else if (item_xfer) begin
			if (in_low) begin
				low_seen_q  <= 1'b1;
				high_seen_q <= 1'b0;
			end else if (in_high) begin
				low_seen_q  <= 1'b0;
				high_seen_q <= 1'b1;
			end
			if (run_end) begin
				run_events_q <= '0;
				ms_since_q   <= '0;
				run_active_q <= 1'b0;
			end else begin
				run_events_q <= events_nxt;
				ms_since_q   <= ms_nxt;
				run_active_q <= active_nxt;
			end
		end
	end

	// length pipeline
	logic [15:0] cnt_s1, cnt_s2, cnt_s3;
	logic [15:0] inches_s2, inches_s3;
	logic [15:0] qest_s3;
	logic        over_s3;

	logic [32:0] prod;
	logic [16:0] inches_full;
	logic [31:0] qprod;

	assign prod        = 33'(cnt_s1) * 33'(inches_q16_q) + ROUND_HALF;
	assign inches_full = prod[32:16];
	assign qprod       = 32'(inches_s2) * 32'(RECIP);

	// remainder correction: the estimate is at most one short
	logic [21:0] qd;
	logic [16:0] rem_est, rem_fix;
	logic [15:0] quot_fix;
	result_t     res_nxt;

	always_comb begin
		qd       = 22'(qest_s3) * 22'(INCHES_PER_FOOT);
		rem_est  = 17'(inches_s3) - qd[16:0];
		rem_fix  = rem_est;
		quot_fix = qest_s3;
		if (rem_est >= DIV) begin
			rem_fix  = rem_est - DIV;
			quot_fix = qest_s3 + 16'd1;
		end
		res_nxt.total_inches = inches_s3;
		res_nxt.feet         = (quot_fix > 16'(FEET_MAX)) ? FEET_MAX : quot_fix[12:0];
		res_nxt.inches_left  = (rem_fix > 17'(INCHES_LEFT_MAX)) ? INCHES_LEFT_MAX
		                                                        : rem_fix[3:0];
		res_nxt.over_limit   = over_s3;
		res_nxt.event_count  = cnt_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= item_xfer && report;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v3_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cnt_s1 <= events_nxt;
		end
		if (rdy2) begin
			cnt_s2    <= cnt_s1;
			inches_s2 <= (inches_full > 17'(CNT_MAX)) ? CNT_MAX : inches_full[15:0];
		end
		if (rdy3) begin
			cnt_s3    <= cnt_s2;
			inches_s3 <= inches_s2;
			qest_s3   <= qprod[31:16];
			over_s3   <= inches_s2 > max_inches_q;
		end
		if (rdy_out) begin
			result <= res_nxt;
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

### design/srlm_checker.sv
// port-level checker for the spool rotation length meter and its bind
`default_nettype none

`include "spool_rotation_length_meter_unit_defines.svh"

module srlm_checker
	import srlm_pkg::*;
#(
	parameter int INCHES_PER_FOOT = 12
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_ready,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire result_t     result
);

	logic [31:0] recombined;
	logic        unsaturated;
	logic        split_ok;

	assign recombined  = 32'(result.feet) * 32'(INCHES_PER_FOOT) + 32'(result.inches_left);
	assign unsaturated = (result.feet != FEET_MAX) && (result.inches_left != INCHES_LEFT_MAX);
	assign split_ok    = (recombined == 32'(result.total_inches));

	// a stalled report holds
	`SRLM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// items wait only behind a stalled report
	`SRLM_ASSERT_NOW(a_ready_backpressure, !item_ready, result_valid && !result_ready)

	// a report always carries at least one event
	`SRLM_ASSERT_NOW(a_count_nonzero, result_valid, result.event_count != 16'd0)

	// feet and inches left rebuild the total unless clipped
	`SRLM_ASSERT_NOW(a_feet_split, result_valid && unsaturated, split_ok)

endmodule

bind spool_rotation_length_meter_unit srlm_checker #(
	.INCHES_PER_FOOT(INCHES_PER_FOOT)
) u_srlm_checker (.*);

`default_nettype wire
